// ----- rtl/core/gsbt_pkg.sv -----
// Shared types and constants for the gas sensor baseline tracker.
package gsbt_pkg;

    localparam int unsigned VAL_W = 16;
    localparam int unsigned STARTUP_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [VAL_W-1:0]     t_val;
    typedef logic [STARTUP_W-1:0] t_startup;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_DAY_LENGTH    = 3'd0;
    localparam t_cfg_idx CFG_STARTUP_TICKS = 3'd1;
    localparam t_cfg_idx CFG_INIT_BASELINE = 3'd2;
    localparam t_cfg_idx CFG_INIT_DAY_MAX  = 3'd3;
    localparam t_cfg_idx CFG_INIT_WEEK_MAX = 3'd4;
    localparam t_cfg_idx CFG_INIT_DAYS     = 3'd5;

    // Values the registers and the tracker state take at reset.
    localparam t_val     RST_DAY_LENGTH = 16'd10000;
    localparam t_startup RST_STARTUP    = 8'd10;
    localparam t_val     RST_BASELINE   = 16'd1;
    localparam t_val     RST_DAY_MAX    = 16'd1;
    localparam t_val     RST_WEEK_MAX   = 16'd1;
    localparam t_val     RST_DAYS       = 16'd0;

    // Operations of the shared arithmetic unit.
    typedef enum logic {
        ALU_MAX,
        ALU_AVG
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        t_val    a;
        t_val    b;
    } t_alu_req;

endpackage

// ----- rtl/core/gsbt_in_if.sv -----
// Input channel: one resistance sample per beat.
interface gsbt_in_if;
    logic                valid;
    logic                ready;
    logic [15:0]         resistance_sample;

    modport source (output valid, output resistance_sample, input ready);
    modport sink   (input valid, input resistance_sample, output ready);
endinterface

// ----- rtl/core/gsbt_out_if.sv -----
// Output channel: one tracker result per beat.
interface gsbt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] baseline;
    logic [15:0] clamped_sample;
    logic [15:0] day_maximum;
    logic [15:0] week_maximum;
    logic [15:0] day_count;
    logic        day_rolled;

    modport source (
        output valid, output baseline, output clamped_sample, output day_maximum,
        output week_maximum, output day_count, output day_rolled, input ready
    );
    modport sink (
        input valid, input baseline, input clamped_sample, input day_maximum,
        input week_maximum, input day_count, input day_rolled, output ready
    );
endinterface

// ----- rtl/core/gas_sensor_baseline_tracker_unit.sv -----
// Top level of the gas sensor baseline tracker: sequencer, history and result register.
// A tick without day rollover goes from its input beat through APPLY_B, APPLY_D and DONE
// to its result beat; a tick that closes a day first runs the serial scan of the history
// through the shared compare unit and the AVG step. One tick is worked on at a time; the
// next input beat is taken as soon as the result sits in the output register. Reset
// (synchronous, active low) loads the tracker state; the data registers are not reset.
module gas_sensor_baseline_tracker_unit #(
    parameter int unsigned HISTORY_DAYS = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  gsbt_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [15:0]            i_cfg_wdata,
    gsbt_in_if.sink                i_sample,
    gsbt_out_if.source             o_result
);

    // The history index only has to reach the last entry of the window.
    localparam int unsigned IDX_W = (HISTORY_DAYS > 1) ? $clog2(HISTORY_DAYS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DAYS - 1);
    localparam gsbt_pkg::t_val HIST_DAYS_V = gsbt_pkg::VAL_W'(HISTORY_DAYS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_AVG     = 3'd2;
    localparam logic [2:0] ST_APPLY_B = 3'd3;
    localparam logic [2:0] ST_APPLY_D = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;

    // Only the day length acts on running behavior. The other registers
    // only seed the state at reset, and reset restores their default values,
    // so the seeds are the package reset constants.
    gsbt_pkg::t_val        r_day_length;

    gsbt_pkg::t_val        r_tick;
    gsbt_pkg::t_val        r_days;
    gsbt_pkg::t_val        r_baseline;
    gsbt_pkg::t_val        r_day_peak;
    gsbt_pkg::t_val        r_week_peak;
    gsbt_pkg::t_val        r_hist [HISTORY_DAYS];
    gsbt_pkg::t_startup    r_startup;

    gsbt_pkg::t_val        r_sample;
    gsbt_pkg::t_val        r_clamped;
    gsbt_pkg::t_val        r_acc;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_rolled;

    logic                  r_out_valid;
    gsbt_pkg::t_val        r_out_baseline;
    gsbt_pkg::t_val        r_out_clamped;
    gsbt_pkg::t_val        r_out_day_max;
    gsbt_pkg::t_val        r_out_week_max;
    gsbt_pkg::t_val        r_out_days;
    logic                  r_out_rolled;

    logic                  in_fire;
    logic                  out_load;
    logic [gsbt_pkg::VAL_W:0] tick_next;
    logic                  day_close;
    gsbt_pkg::t_val        avg_target;
    gsbt_pkg::t_alu_req    alu_req;
    gsbt_pkg::t_val        alu_y;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign in_fire        = i_sample.valid && i_sample.ready;

    // The tick count grows with one extra bit so that a day length of all ones
    // still closes a day after the full count.
    assign tick_next = {1'b0, r_tick} + {{gsbt_pkg::VAL_W{1'b0}}, 1'b1};
    assign day_close = tick_next > {1'b0, r_day_length};

    // Once the day count exceeds HISTORY_DAYS the baseline chases the week maximum; before that,
    // and again after the day count wraps, it chases the closing day's maximum.
    assign avg_target = (r_days > HIST_DAYS_V) ? r_acc : r_day_peak;

    // A finished result waits in the output register only until it is taken.
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_result.ready);

    // Feed the shared unit according to the step in progress.
    always_comb begin
        alu_req.op = gsbt_pkg::ALU_MAX;
        alu_req.a  = r_baseline;
        alu_req.b  = r_sample;
        unique case (r_state)
            ST_SCAN: begin
                alu_req.a = r_acc;
                alu_req.b = r_hist[r_idx];
            end
            ST_AVG: begin
                alu_req.op = gsbt_pkg::ALU_AVG;
                alu_req.b  = avg_target;
            end
            ST_APPLY_D: begin
                alu_req.a = r_day_peak;
            end
            default: begin
            end
        endcase
    end

    gsbt_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_fire) n_state = day_close ? ST_SCAN : ST_APPLY_B;
            ST_SCAN:    if (r_idx == IDX_LAST) n_state = ST_AVG;
            ST_AVG:     n_state = ST_APPLY_B;
            ST_APPLY_B: n_state = ST_APPLY_D;
            ST_APPLY_D: n_state = ST_DONE;
            ST_DONE:    if (out_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_day_length <= gsbt_pkg::RST_DAY_LENGTH;
            r_tick       <= '0;
            r_days       <= gsbt_pkg::RST_DAYS;
            r_baseline   <= gsbt_pkg::RST_BASELINE;
            r_day_peak   <= gsbt_pkg::RST_DAY_MAX;
            r_week_peak  <= gsbt_pkg::RST_WEEK_MAX;
            r_startup    <= gsbt_pkg::RST_STARTUP;
            for (int i = 0; i < HISTORY_DAYS; i++) begin
                r_hist[i] <= gsbt_pkg::RST_WEEK_MAX;
            end
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we && (i_cfg_idx == gsbt_pkg::CFG_DAY_LENGTH)) begin
                r_day_length <= i_cfg_wdata;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_sample <= i_sample.resistance_sample;
                        r_rolled <= day_close;
                        r_acc    <= '0;
                        r_idx    <= '0;
                        if (r_startup != '0) begin
                            r_startup <= r_startup - gsbt_pkg::STARTUP_W'(1);
                        end
                        if (day_close) begin
                            r_tick <= '0;
                            r_days <= r_days + gsbt_pkg::VAL_W'(1);
                            for (int i = 0; i < HISTORY_DAYS - 1; i++) begin
                                r_hist[i] <= r_hist[i+1];
                            end
                            r_hist[HISTORY_DAYS-1] <= r_day_peak;
                        end else begin
                            r_tick <= tick_next[gsbt_pkg::VAL_W-1:0];
                        end
                    end
                end
                ST_SCAN: begin
                    r_acc <= alu_y;
                    r_idx <= r_idx + IDX_W'(1);
                end
                ST_AVG: begin
                    r_week_peak <= r_acc;
                    r_baseline  <= alu_y;
                    r_day_peak  <= '0;
                end
                ST_APPLY_B: begin
                    // After startup a higher sample lifts the baseline at once;
                    // during startup the sample is only clamped up to it.
                    if (r_startup == '0) begin
                        r_baseline <= alu_y;
                        r_clamped  <= r_sample;
                    end else begin
                        r_clamped  <= alu_y;
                    end
                end
                ST_APPLY_D: begin
                    if (r_startup == '0) begin
                        r_day_peak <= alu_y;
                    end
                end
                default: begin
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_baseline <= r_baseline;
            r_out_clamped  <= r_clamped;
            r_out_day_max  <= r_day_peak;
            r_out_week_max <= r_week_peak;
            r_out_days     <= r_days;
            r_out_rolled   <= r_rolled;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.baseline       = r_out_baseline;
    assign o_result.clamped_sample = r_out_clamped;
    assign o_result.day_maximum    = r_out_day_max;
    assign o_result.week_maximum   = r_out_week_max;
    assign o_result.day_count      = r_out_days;
    assign o_result.day_rolled     = r_out_rolled;

    // An accepted beat starts a tick, and no second beat is taken right after it.
    a_one_tick_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_sample.ready)
        else $error("input beat taken while a tick was still being worked on");

    // The startup countdown only steps down by one.
    a_startup_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_startup != $past(r_startup)))
            |-> (r_startup == $past(r_startup) - gsbt_pkg::STARTUP_W'(1)))
        else $error("startup countdown moved other than down by one");

    // The history scan never runs past the last entry.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= IDX_LAST))
        else $error("history scan index out of range");

    // The week maximum changes only while a day is being closed.
    a_week_only_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_week_peak != $past(r_week_peak)))
            |-> ($past(r_state) == ST_AVG))
        else $error("week maximum changed outside of day close");

endmodule

// ----- rtl/core/gsbt_alu.sv -----
// Shared compare and average unit used by the tracker sequencer.
module gsbt_alu (
    input  gsbt_pkg::t_alu_req i_req,
    output gsbt_pkg::t_val     o_y
);

    logic [gsbt_pkg::VAL_W:0] sum;

    assign sum = {1'b0, i_req.a} + {1'b0, i_req.b};

    always_comb begin
        unique case (i_req.op)
            gsbt_pkg::ALU_MAX: o_y = (i_req.b > i_req.a) ? i_req.b : i_req.a;
            gsbt_pkg::ALU_AVG: o_y = sum[gsbt_pkg::VAL_W:1];
            default:           o_y = i_req.a;
        endcase
    end

endmodule
